// ----- sv/mfbp_pkg.sv -----
// Shared types and constants for the MSB-first bit packer.
package mfbp_pkg;

   localparam int BYTE_BITS      = 8;
   localparam int CODE_WORD_BITS = 32;
   localparam int COUNT_BITS     = 6;
   // Left-aligned code word holds every bit a 6-bit count can ask for
   localparam int ALIGN_BITS     = 64;
   localparam int MAX_CODE_BITS  = 32;
   localparam int QUEUE_DEPTH    = 2;

   typedef struct packed {
      logic [ALIGN_BITS-1:0] bits;
      logic [COUNT_BITS-1:0] count;
      logic                  flush;
   } mfbp_item_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } mfbp_back_state_type;

endpackage

// ----- sv/mfbp_if.sv -----
// Valid/ready channel interfaces for packer items and output bytes.
interface mfbp_req_if;
   logic                                valid;
   logic                                ready;
   logic [mfbp_pkg::CODE_WORD_BITS-1:0] code_word;
   logic [mfbp_pkg::COUNT_BITS-1:0]     bit_count;
   logic                                flush_req;

   modport source (output valid, code_word, bit_count, flush_req, input ready);
   modport sink   (input valid, code_word, bit_count, flush_req, output ready);
endinterface

interface mfbp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mfbp_pkg::BYTE_BITS-1:0] out_byte;
   logic                           last_of_run;

   modport source (output valid, out_byte, last_of_run, input ready);
   modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

// ----- sv/mfbp_front.sv -----
// Front end: saturates the bit count and left-aligns the code word.
module mfbp_front #(
   parameter int MAX_CODE_BITS = mfbp_pkg::MAX_CODE_BITS
) (
   mfbp_req_if.sink               req_chan,
   input  logic                   queue_full,
   output logic                   push,
   output mfbp_pkg::mfbp_item_type item
);

   localparam logic [mfbp_pkg::COUNT_BITS:0] MaxCount = (mfbp_pkg::COUNT_BITS+1)'(MAX_CODE_BITS);
   localparam logic [mfbp_pkg::COUNT_BITS:0] AlignCount =
      (mfbp_pkg::COUNT_BITS+1)'(mfbp_pkg::ALIGN_BITS);

   logic [mfbp_pkg::COUNT_BITS-1:0] count_sat;
   logic [mfbp_pkg::COUNT_BITS:0]   shift_amt;
   logic [mfbp_pkg::ALIGN_BITS-1:0] word_ext;

   always_comb begin
      if ({1'b0, req_chan.bit_count} > MaxCount) begin
         count_sat = MaxCount[mfbp_pkg::COUNT_BITS-1:0];
      end else begin
         count_sat = req_chan.bit_count;
      end
      // Put the first bit to append at the top of the aligned word
      shift_amt = AlignCount - {1'b0, count_sat};
      word_ext  = {{(mfbp_pkg::ALIGN_BITS-mfbp_pkg::CODE_WORD_BITS){1'b0}},
                   req_chan.code_word};
      item.bits  = word_ext << shift_amt;
      item.count = count_sat;
      item.flush = req_chan.flush_req;
   end

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

endmodule

// ----- sv/mfbp_queue.sv -----
// Short item queue between the front end and the packing sequencer.
module mfbp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  mfbp_pkg::mfbp_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    not_empty,
   output mfbp_pkg::mfbp_item_type head_item
);

   localparam int PtrBits = $clog2(mfbp_pkg::QUEUE_DEPTH);
   localparam int CntBits = $clog2(mfbp_pkg::QUEUE_DEPTH + 1);
   localparam logic [CntBits-1:0] Depth = CntBits'(mfbp_pkg::QUEUE_DEPTH);
   localparam logic [PtrBits-1:0] LastPtr = PtrBits'(mfbp_pkg::QUEUE_DEPTH - 1);

   mfbp_pkg::mfbp_item_type entry_ff [mfbp_pkg::QUEUE_DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full      = (cnt_ff == Depth);
   assign not_empty = (cnt_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/mfbp_back.sv -----
// Packing sequencer: shifts bits into the holding byte and emits bytes.
module mfbp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  mfbp_pkg::mfbp_item_type item,
   output logic                    pop,
   mfbp_rsp_if.source              rsp_chan
);

   localparam int BB = mfbp_pkg::BYTE_BITS;
   localparam int HB = $clog2(BB + 1);
   localparam int AB = mfbp_pkg::ALIGN_BITS;
   localparam int CB = mfbp_pkg::COUNT_BITS;
   localparam logic [HB-1:0] FullCount = HB'(BB);

   mfbp_pkg::mfbp_back_state_type state_ff, state_in;

   logic [BB-1:0] held_ff, held_in;
   logic [HB-1:0] hcnt_ff, hcnt_in;
   logic [AB-1:0] bits_ff, bits_in;
   logic [CB-1:0] rem_ff, rem_in;
   logic          flush_ff, flush_in;
   logic          ovalid_ff, ovalid_in;
   logic [BB-1:0] obyte_ff, obyte_in;
   logic          olast_ff, olast_in;

   logic            slot_free;
   logic            full;
   logic [HB-1:0]   base_cnt;
   logic [HB-1:0]   room;
   logic [HB-1:0]   take;
   logic [BB-1:0]   base;
   logic [2*BB-1:0] shifted;
   logic [BB-1:0]   padded;
   logic            load, step, finish, emit;
   logic [BB-1:0]   emit_byte;
   logic            emit_last;

   assign slot_free = !ovalid_ff || rsp_chan.ready;
   assign full      = (hcnt_ff == FullCount);
   assign base_cnt  = full ? '0 : hcnt_ff;
   assign base      = full ? '0 : held_ff;
   assign room      = FullCount - base_cnt;
   assign take      = ({{(CB-HB){1'b0}}, room} > rem_ff) ? HB'(rem_ff) : room;
   assign shifted   = {base, bits_ff[AB-1 -: BB]} << take;
   assign padded    = held_ff << (FullCount - hcnt_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfbp_pkg::BK_IDLE: begin
            if (item_valid) begin
               state_in = mfbp_pkg::BK_RUN;
            end
         end
         mfbp_pkg::BK_RUN: begin
            if (finish) begin
               state_in = mfbp_pkg::BK_IDLE;
            end
         end
         default: state_in = mfbp_pkg::BK_IDLE;
      endcase
   end

   // Sequencer controls
   always_comb begin
      load      = 1'b0;
      step      = 1'b0;
      finish    = 1'b0;
      emit      = 1'b0;
      emit_byte = held_ff;
      emit_last = 1'b0;
      unique case (state_ff)
         mfbp_pkg::BK_IDLE: begin
            load = item_valid;
         end
         mfbp_pkg::BK_RUN: begin
            if (rem_ff != '0) begin
               // A full byte goes out only when a further bit arrives
               if (!full || slot_free) begin
                  step      = 1'b1;
                  emit      = full;
                  emit_last = (rem_ff == CB'(take)) && !flush_ff;
               end
            end else if (flush_ff && (hcnt_ff != '0)) begin
               if (slot_free) begin
                  finish    = 1'b1;
                  emit      = 1'b1;
                  emit_byte = padded;
                  emit_last = 1'b1;
               end
            end else begin
               finish = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign pop = load;

   always_comb begin
      held_in  = held_ff;
      hcnt_in  = hcnt_ff;
      bits_in  = bits_ff;
      rem_in   = rem_ff;
      flush_in = flush_ff;
      if (load) begin
         bits_in  = item.bits;
         rem_in   = item.count;
         flush_in = item.flush;
      end else if (step) begin
         held_in = shifted[2*BB-1 -: BB];
         hcnt_in = base_cnt + take;
         bits_in = bits_ff << take;
         rem_in  = rem_ff - CB'(take);
      end else if (finish && emit) begin
         held_in = '0;
         hcnt_in = '0;
      end
   end

   always_comb begin
      ovalid_in = ovalid_ff;
      obyte_in  = obyte_ff;
      olast_in  = olast_ff;
      if (emit) begin
         ovalid_in = 1'b1;
         obyte_in  = emit_byte;
         olast_in  = emit_last;
      end else if (rsp_chan.ready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mfbp_pkg::BK_IDLE;
         held_ff   <= '0;
         hcnt_ff   <= '0;
         rem_ff    <= '0;
         flush_ff  <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         held_ff   <= held_in;
         hcnt_ff   <= hcnt_in;
         rem_ff    <= rem_in;
         flush_ff  <= flush_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff  <= bits_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
   end

   assign rsp_chan.valid       = ovalid_ff;
   assign rsp_chan.out_byte    = obyte_ff;
   assign rsp_chan.last_of_run = olast_ff;

endmodule

// ----- sv/msb_first_bit_packer.sv -----
// MSB-first variable-length bit packer: front end, item queue and packing sequencer.
// Each item appends the low bit_count bits of code_word (count saturated to
// MAX_CODE_BITS) to an 8-bit holding byte, first bit at the MSB; a full byte
// is sent only when a further bit arrives or a flush pads and sends it. The
// packing sequencer handles an item as a load step, one fill step of up to 8
// bits per holding-byte fill (5 steps for 32 bits that straddle a byte
// boundary) and a closing step that also sends a flushed byte; a step that
// sends a byte waits while the output is stalled. A two-entry queue lets new
// items be taken while the sequencer works.
module msb_first_bit_packer #(
   parameter int MAX_CODE_BITS = mfbp_pkg::MAX_CODE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   mfbp_req_if.sink   req_chan,
   mfbp_rsp_if.source rsp_chan
);

   logic                    queue_full;
   logic                    push;
   logic                    pop;
   logic                    head_valid;
   mfbp_pkg::mfbp_item_type front_item;
   mfbp_pkg::mfbp_item_type head_item;

   mfbp_front #(
      .MAX_CODE_BITS(MAX_CODE_BITS)
   ) u_front (
      .req_chan  (req_chan),
      .queue_full(queue_full),
      .push      (push),
      .item      (front_item)
   );

   mfbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(front_item),
      .full     (queue_full),
      .pop      (pop),
      .not_empty(head_valid),
      .head_item(head_item)
   );

   mfbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .item_valid(head_valid),
      .item      (head_item),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- sv/mfbp_checker.sv -----
// Port-level assertions for the bit packer, bound to the top level.
module mfbp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [mfbp_pkg::BYTE_BITS-1:0] rsp_out_byte,
   input logic                           rsp_last_of_run
);

   // Output register is cleared by reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Queue is empty after reset, so items are taken at once
   a_req_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready right after reset");

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_out_byte) && $stable(rsp_last_of_run)))
      else $error("result changed while stalled");

endmodule

bind msb_first_bit_packer mfbp_checker u_mfbp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_byte   (rsp_chan.out_byte),
   .rsp_last_of_run(rsp_chan.last_of_run)
);

// ----- tb/tb_msb_first_bit_packer.sv -----
// Self-checking testbench for the MSB-first bit packer: directed, random and stall tests.
module tb_msb_first_bit_packer;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_TAIL  = 24;

   typedef struct {
      logic [mfbp_pkg::BYTE_BITS-1:0] out_byte;
      logic                           last_of_run;
   } packed_byte_type;

   logic clock;
   logic reset;

   mfbp_req_if req_chan ();
   mfbp_rsp_if rsp_chan ();

   msb_first_bit_packer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // Predicted packer state and bytes still to come
   logic [mfbp_pkg::BYTE_BITS-1:0] model_held_bits;
   logic [3:0]                     model_held_count;
   packed_byte_type                expected_bytes[$];

   int failures;
   int src_idle_pct;
   int sink_idle_pct;
   int rx_hold_pending;
   int rx_hold_left;
   int stall_cycles;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic void predict_packed_bytes(
      input logic [mfbp_pkg::CODE_WORD_BITS-1:0] word,
      input logic [mfbp_pkg::COUNT_BITS-1:0]     count_in,
      input logic                                flush);
      int              count;
      int              pos;
      packed_byte_type run[$];
      packed_byte_type entry;
      count = (count_in > mfbp_pkg::MAX_CODE_BITS) ? mfbp_pkg::MAX_CODE_BITS : int'(count_in);
      for (pos = count - 1; pos >= 0; pos--) begin
         // a full byte leaves only when a further bit shows up
         if (model_held_count >= mfbp_pkg::BYTE_BITS) begin
            entry.out_byte    = model_held_bits;
            entry.last_of_run = 1'b0;
            run.push_back(entry);
            model_held_bits  = '0;
            model_held_count = '0;
         end
         model_held_bits  = {model_held_bits[mfbp_pkg::BYTE_BITS-2:0], word[pos]};
         model_held_count = model_held_count + 4'd1;
      end
      if (flush && model_held_count > 0) begin
         entry.out_byte    = model_held_bits << (mfbp_pkg::BYTE_BITS - int'(model_held_count));
         entry.last_of_run = 1'b0;
         run.push_back(entry);
         model_held_bits  = '0;
         model_held_count = '0;
      end
      if (run.size() > 0)
         run[run.size()-1].last_of_run = 1'b1;
      foreach (run[i])
         expected_bytes.push_back(run[i]);
   endfunction

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(input logic [mfbp_pkg::CODE_WORD_BITS-1:0] word,
                            input logic [mfbp_pkg::COUNT_BITS-1:0]     count,
                            input logic                                flush);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.code_word <= word;
      req_chan.bit_count <= count;
      req_chan.flush_req <= flush;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      predict_packed_bytes(word, count, flush);
   endtask

   task automatic send_random_item();
      int                              pick;
      logic [mfbp_pkg::COUNT_BITS-1:0] count;
      pick = $urandom_range(99);
      if (pick < 10)
         count = '0;
      else if (pick < 80)
         count = mfbp_pkg::COUNT_BITS'($urandom_range(mfbp_pkg::MAX_CODE_BITS, 1));
      else if (pick < 90)
         count = mfbp_pkg::COUNT_BITS'(mfbp_pkg::MAX_CODE_BITS);
      else
         count = mfbp_pkg::COUNT_BITS'($urandom_range(63, mfbp_pkg::MAX_CODE_BITS + 1));
      send_item($urandom, count, ($urandom_range(3) == 0));
   endtask

   task automatic test_directed_cases();
      send_item(32'h0000_0000, 6'd0,  1'b0);   // zero count, nothing happens
      send_item(32'h0000_0000, 6'd0,  1'b1);   // flush with empty register
      send_item(32'hFFFF_FFFF, 6'd32, 1'b0);   // full register left held
      send_item(32'h0000_0000, 6'd0,  1'b1);   // zero count still flushes
      send_item(32'h0000_00A5, 6'd8,  1'b0);
      send_item(32'h0000_0001, 6'd1,  1'b0);   // extra bit pushes out the held byte
      send_item(32'h0000_0000, 6'd0,  1'b1);
      send_item(32'h0000_007F, 6'd7,  1'b0);
      send_item(32'hAAAA_AAAA, 6'd32, 1'b1);   // straddles bytes, five bytes out
      send_item(32'hFFFF_FFFF, 6'd63, 1'b1);   // oversized counts saturate
      send_item(32'h1234_5678, 6'd33, 1'b1);
      send_item(32'h8000_0001, 6'd40, 1'b0);
      send_item(32'h0000_0005, 6'd3,  1'b0);
      send_item(32'h0000_0003, 6'd2,  1'b1);
      send_item(32'hFFFF_FFFE, 6'd1,  1'b1);   // only the low bit is used
      send_item(32'h5555_5555, 6'd31, 1'b0);
      send_item(32'h0000_0000, 6'd32, 1'b1);
      send_item(32'hDEAD_BEEF, 6'd16, 1'b0);
      send_item(32'h0000_0001, 6'd8,  1'b1);
   endtask

   task automatic test_random_mix();
      repeat (320) send_random_item();
   endtask

   // Stall the output long enough for the input to back up
   task automatic test_back_pressure();
      src_idle_pct    = 0;
      rx_hold_pending = 300;
      repeat (50) send_random_item();
      src_idle_pct = 34;
   endtask

   task automatic test_full_rate();
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      repeat (80) send_random_item();
      src_idle_pct  = 34;
      sink_idle_pct = 34;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rx_hold_pending != 0) begin
            rx_hold_left    = rx_hold_pending;
            rx_hold_pending = 0;
         end
         if (rx_hold_left > 0) begin
            rx_hold_left   = rx_hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      packed_byte_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_bytes.size() == 0) begin
            $error("out_byte: expected none, actual %02h", rsp_chan.out_byte);
            failures++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_chan.out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, actual %02h", want.out_byte, rsp_chan.out_byte);
               failures++;
            end
            if (rsp_chan.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0b, actual %0b",
                      want.last_of_run, rsp_chan.last_of_run);
               failures++;
            end
         end
      end
   end

   // Count cycles in which neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      failures           = 0;
      src_idle_pct       = 34;
      sink_idle_pct      = 34;
      rx_hold_pending    = 0;
      model_held_bits    = '0;
      model_held_count   = '0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.code_word = '0;
      req_chan.bit_count = '0;
      req_chan.flush_req = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_mix();
      test_back_pressure();
      test_full_rate();
      req_chan.valid <= 1'b0;

      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);

      if (failures == 0 && expected_bytes.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/mfbp_pkg.sv
sv/mfbp_if.sv
sv/mfbp_front.sv
sv/mfbp_queue.sv
sv/mfbp_back.sv
sv/msb_first_bit_packer.sv
sv/mfbp_checker.sv
tb/tb_msb_first_bit_packer.sv
